FILE: hw/rtl/hex_record_flash_writer_core_macros.svh
// Assertion macros used by the top level of the hex record flash writer RTL.
`ifndef HEX_RECORD_FLASH_WRITER_CORE_MACROS_SVH
`define HEX_RECORD_FLASH_WRITER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HRFW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HRFW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/hrfw_pkg.sv
// Types and constants of the hex record flash writer.
`default_nettype none

package hrfw_pkg;

  localparam logic [31:0] FlashBaseReset = 32'h0800_0000;

  localparam logic [7:0] CharColon      = 8'h3A;
  localparam logic [7:0] CharZero       = 8'h30;
  localparam logic [7:0] CharNine       = 8'h39;
  localparam logic [7:0] HexAlphaOffset = 8'd55;

  // Character positions within a record, colon at zero.
  localparam logic [9:0] PosCountLo  = 10'd1;
  localparam logic [9:0] PosCountHi  = 10'd2;
  localparam logic [9:0] PosOffsetLo = 10'd3;
  localparam logic [9:0] PosOffsetHi = 10'd6;
  localparam logic [9:0] PosKind     = 10'd8;
  localparam logic [9:0] PosDataLo   = 10'd9;
  localparam logic [9:0] PosMax      = 10'd1023;

  localparam logic [1:0] PhaseLastDigit = 2'd3;
  localparam logic [3:0] KindData       = 4'd0;

  typedef struct packed {
    logic        valid;
    logic [31:0] address;
    logic [15:0] halfword;
    logic        last;
  } hrfw_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hrfw_parser.sv
// Record field tracking and halfword assembly for one character per cycle while step_i is high.
`default_nettype none

module hrfw_parser
  import hrfw_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   char_i,
  input  logic [31:0]  flash_base_i,
  output hrfw_result_t result_o
);

  logic [9:0]  pos_q, pos_d;
  logic        in_record_q, in_record_d;
  logic [7:0]  byte_count_q, byte_count_d;
  logic [15:0] offset_q, offset_d;
  logic [3:0]  kind_q, kind_d;
  logic [11:0] partial_q, partial_d;
  logic [6:0]  index_q, index_d;

  logic       is_colon;
  logic [7:0] digit_diff;
  logic [3:0] nib;
  logic [9:0] pos_next;
  logic [9:0] data_pos;
  logic [1:0] phase;
  logic [6:0] half_count;
  logic       data_active;
  logic       emit;

  always_comb begin
    is_colon = (char_i == CharColon);
    if (char_i >= CharZero && char_i <= CharNine) begin
      digit_diff = char_i - CharZero;
    end else begin
      digit_diff = char_i - HexAlphaOffset;
    end
    nib         = digit_diff[3:0];
    pos_next    = (pos_q < PosMax) ? pos_q + 10'd1 : pos_q;
    data_pos    = pos_next - PosDataLo;
    phase       = data_pos[1:0];
    half_count  = byte_count_q[7:1];
    data_active = (pos_next >= PosDataLo) && (pos_next < PosMax) &&
                  (kind_q == KindData) && (index_q < half_count);
    emit        = step_i && !is_colon && in_record_q && data_active &&
                  (phase == PhaseLastDigit);
  end

  always_comb begin
    pos_d        = pos_q;
    in_record_d  = in_record_q;
    byte_count_d = byte_count_q;
    offset_d     = offset_q;
    kind_d       = kind_q;
    partial_d    = partial_q;
    index_d      = index_q;
    if (step_i) begin
      if (is_colon) begin
        // Restart the record from scratch.
        pos_d        = '0;
        in_record_d  = 1'b1;
        byte_count_d = '0;
        offset_d     = '0;
        kind_d       = '0;
        partial_d    = '0;
        index_d      = '0;
      end else if (in_record_q) begin
        pos_d = pos_next;
        priority if (pos_next == PosCountLo || pos_next == PosCountHi) begin
          byte_count_d = {byte_count_q[3:0], nib};
        end else if (pos_next >= PosOffsetLo && pos_next <= PosOffsetHi) begin
          offset_d = {offset_q[11:0], nib};
        end else if (pos_next == PosKind) begin
          kind_d = nib;
        end else if (data_active) begin
          if (phase != PhaseLastDigit) begin
            partial_d = {partial_q[7:0], nib};
          end else begin
            partial_d = '0;
            index_d   = index_q + 7'd1;
          end
        end else begin
          // Hold fields: type high digit, checksum, trailing characters.
          partial_d = partial_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      in_record_q  <= 1'b0;
      byte_count_q <= '0;
      offset_q     <= '0;
      kind_q       <= '0;
      partial_q    <= '0;
      index_q      <= '0;
    end else begin
      pos_q        <= pos_d;
      in_record_q  <= in_record_d;
      byte_count_q <= byte_count_d;
      offset_q     <= offset_d;
      kind_q       <= kind_d;
      partial_q    <= partial_d;
      index_q      <= index_d;
    end
  end

  // First data byte lands in the low eight bits.
  always_comb begin
    result_o.valid    = emit;
    result_o.address  = (flash_base_i | {16'b0, offset_q}) + {24'b0, index_q, 1'b0};
    result_o.halfword = {partial_q[3:0], nib, partial_q[11:8], partial_q[7:4]};
    result_o.last     = (({1'b0, index_q} + 8'd1) == {1'b0, half_count});
  end

endmodule

`default_nettype wire

FILE: hw/rtl/hex_record_flash_writer_core.sv
// Hex record text to halfword flash write converter, top level.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/text_char_i) takes one ASCII
//   character per transfer. A colon opens a record; data records produce one
//   write per four data characters on the output channel (out_valid_o/
//   out_ready_i) with address, halfword and a last-in-record flag.
//   Config channel (cfg_valid_i/cfg_ready_o/flash_base_i) loads the base
//   address; it is always ready and should be written while the block idles.
//   Throughput: one character per cycle while the output is not held, set by the single parse stage.
//   Path: the character that completes a halfword passes the input register,
//   then the result register, before its write appears on the output channel.
//   Reset: no record open, base address 0x0800_0000, both stages empty.
//   Stall: a held output keeps its result; the input register still takes
//   one more character, and in_ready_o drops only when both stages are full.
`default_nettype none

`include "hex_record_flash_writer_core_macros.svh"

module hex_record_flash_writer_core
  import hrfw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_char_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] flash_base_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] write_address_o,
  output logic [15:0] write_halfword_o,
  output logic        last_in_record_o
);

  logic        s1_valid_q;
  logic [7:0]  s1_char_q;
  logic [31:0] base_q;
  logic        out_valid_q;
  logic [31:0] out_address_q;
  logic [15:0] out_halfword_q;
  logic        out_last_q;

  logic         s1_fire;
  logic         in_fire;
  hrfw_result_t res;

  assign s1_fire     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_fire;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  hrfw_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (s1_fire),
    .char_i       (s1_char_q),
    .flash_base_i (base_q),
    .result_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      base_q      <= FlashBaseReset;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (res.valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        base_q <= flash_base_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_char_q <= text_char_i;
    end
    if (res.valid) begin
      out_address_q  <= res.address;
      out_halfword_q <= res.halfword;
      out_last_q     <= res.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign write_address_o  = out_address_q;
  assign write_halfword_o = out_halfword_q;
  assign last_in_record_o = out_last_q;

  `HRFW_ASSERT_NOW(a_result_from_fire, clk_i, rst_ni, res.valid, s1_fire, "result without stage fire")
  `HRFW_ASSERT_NOW(a_result_slot_free, clk_i, rst_ni, res.valid, !out_valid_q || out_ready_i, "result overwrites pending output")
  `HRFW_ASSERT_NEXT(a_stage_holds, clk_i, rst_ni, s1_valid_q && !s1_fire, s1_valid_q && $stable(s1_char_q), "stalled character lost")
  `HRFW_ASSERT_NOW(a_ready_low_cause, clk_i, rst_ni, !in_ready_o, s1_valid_q && out_valid_q && !out_ready_i, "input stalled without full pipeline")

endmodule

`default_nettype wire

FILE: sim/hrfw_write_checker.sv
// Monitor and scoreboard for the hex record flash writer: models the parser, checks each write.

module hrfw_write_checker
  import hrfw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  text_char_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] flash_base_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] write_address_i,
  input  logic [15:0] write_halfword_i,
  input  logic        last_in_record_i,
  output int          mismatches_o,
  output int          pending_o,
  output int          writes_o
);

  typedef struct packed {
    logic [31:0] address;
    logic [15:0] halfword;
    logic        last;
  } flash_write_t;

  // Parser state mirrored from the block.
  logic [9:0]  char_pos;
  logic        record_open;
  logic [7:0]  byte_total;
  logic [15:0] offset;
  logic [3:0]  kind;
  logic [11:0] digits;
  logic [6:0]  hw_done;
  logic [31:0] base;

  flash_write_t expected_writes[$];
  flash_write_t oldest;

  // Digits convert by subtraction; letters assume uppercase, keep the low nibble.
  function automatic logic [3:0] nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c >= CharZero && c <= CharNine) v = c - CharZero;
    else v = c - HexAlphaOffset;
    return v[3:0];
  endfunction

  task automatic absorb_char(input logic [7:0] c);
    logic [3:0]   nib;
    logic [1:0]   phase;
    flash_write_t w;
    nib = nibble(c);
    if (c == CharColon) begin
      char_pos    = '0;
      record_open = 1'b1;
      byte_total  = '0;
      offset      = '0;
      kind        = '0;
      digits      = '0;
      hw_done     = '0;
    end else if (record_open) begin
      if (char_pos != PosMax) char_pos = char_pos + 10'd1;
      if (char_pos == PosCountLo || char_pos == PosCountHi) begin
        byte_total = {byte_total[3:0], nib};
      end else if (char_pos >= PosOffsetLo && char_pos <= PosOffsetHi) begin
        offset = {offset[11:0], nib};
      end else if (char_pos == PosKind) begin
        kind = nib;
      end else if (char_pos >= PosDataLo && char_pos != PosMax && kind == KindData &&
                   hw_done < byte_total[7:1]) begin
        phase = 2'(char_pos - PosDataLo);
        if (phase != PhaseLastDigit) begin
          digits = {digits[7:0], nib};
        end else begin
          // First byte of the halfword lands in the low eight bits.
          w.address  = (base | {16'h0000, offset}) + {24'h000000, hw_done, 1'b0};
          w.halfword = {digits[3:0], nib, digits[11:8], digits[7:4]};
          w.last     = (hw_done + 7'd1 == byte_total[7:1]);
          expected_writes.push_back(w);
          hw_done = hw_done + 7'd1;
          digits  = '0;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_pos     = '0;
      record_open  = 1'b0;
      byte_total   = '0;
      offset       = '0;
      kind         = '0;
      digits       = '0;
      hw_done      = '0;
      base         = FlashBaseReset;
      expected_writes.delete();
      mismatches_o = 0;
      writes_o     = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_writes.size() == 0) begin
          $error("unexpected flash write: address %h halfword %h last %b",
                 write_address_i, write_halfword_i, last_in_record_i);
          mismatches_o++;
        end else begin
          oldest = expected_writes.pop_front();
          writes_o++;
          if (write_address_i !== oldest.address) begin
            $error("write_address: expected %h, got %h", oldest.address, write_address_i);
            mismatches_o++;
          end
          if (write_halfword_i !== oldest.halfword) begin
            $error("write_halfword: expected %h, got %h", oldest.halfword, write_halfword_i);
            mismatches_o++;
          end
          if (last_in_record_i !== oldest.last) begin
            $error("last_in_record: expected %b, got %b", oldest.last, last_in_record_i);
            mismatches_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) base = flash_base_i;
      if (in_valid_i && in_ready_i) absorb_char(text_char_i);
    end
    pending_o = expected_writes.size();
  end

endmodule

FILE: sim/hex_record_flash_writer_core_tb.sv
// Testbench top for the hex record flash writer: record stimulus, idle phases and verdict.

module hex_record_flash_writer_core_tb;
  import hrfw_pkg::*;

  localparam int NumPhases     = 5;
  localparam int CharsPerPhase = 140;
  localparam int ConfigHoldoff = 4;
  localparam int DrainCycles   = 8;
  localparam int CycleLimit    = 200000;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [7:0]  text_char_i  = 8'h00;
  logic        cfg_valid_i  = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] flash_base_i = 32'h0000_0000;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b1;
  logic [31:0] write_address_o;
  logic [15:0] write_halfword_o;
  logic        last_in_record_o;

  int send_gap_pct = 0;
  int stall_pct    = 0;
  int chars_sent   = 0;
  int cycle_count  = 0;
  int mismatches;
  int pending;
  int writes_checked;

  hex_record_flash_writer_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .text_char_i      (text_char_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .flash_base_i     (flash_base_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .write_address_o  (write_address_o),
    .write_halfword_o (write_halfword_o),
    .last_in_record_o (last_in_record_o)
  );

  hrfw_write_checker u_write_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .text_char_i      (text_char_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .flash_base_i     (flash_base_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .write_address_i  (write_address_o),
    .write_halfword_i (write_halfword_o),
    .last_in_record_i (last_in_record_o),
    .mismatches_o     (mismatches),
    .pending_o        (pending),
    .writes_o         (writes_checked)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) < stall_pct) ? 1'b0 : 1'b1;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CharZero + 8'(n);
    return HexAlphaOffset + 8'(n);
  endfunction

  // Hold valid and payload until the transfer.
  task automatic send_char(input logic [7:0] c, input bit counted);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_char_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    if (counted) chars_sent++;
  endtask

  // Send a record with random offset and content; stop after cut characters if cut >= 0.
  task automatic send_record(input logic [7:0] count, input logic [3:0] kind, input int cut);
    logic [7:0]  chars[$];
    logic [15:0] ofs;
    logic [7:0]  d;
    ofs = 16'($urandom);
    if ($urandom_range(7) == 0) ofs = {16{ofs[0]}};
    chars.push_back(CharColon);
    chars.push_back(hex_char(count[7:4]));
    chars.push_back(hex_char(count[3:0]));
    chars.push_back(hex_char(ofs[15:12]));
    chars.push_back(hex_char(ofs[11:8]));
    chars.push_back(hex_char(ofs[7:4]));
    chars.push_back(hex_char(ofs[3:0]));
    chars.push_back(hex_char(4'($urandom)));
    chars.push_back(hex_char(kind));
    // Data plus two checksum characters.
    for (int i = 0; i < 2 * int'(count) + 2; i++) begin
      d = hex_char(4'($urandom));
      if ($urandom_range(15) == 0) d = 8'($urandom);
      else if (d > CharNine && $urandom_range(7) == 0) d = d + 8'h20;
      chars.push_back(d);
    end
    for (int i = 0; i < chars.size() && (cut < 0 || i < cut); i++) send_char(chars[i], 1'b1);
  endtask

  task automatic write_base(input logic [31:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (ConfigHoldoff) @(posedge clk_i);
    cfg_valid_i  <= 1'b1;
    flash_base_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    string       prelude;
    logic [31:0] bases[NumPhases];
    logic [7:0]  cnt;
    logic [7:0]  d;
    int          r;
    int          phase_start;

    bases = '{FlashBaseReset, 32'hFFFF_FFFF, 32'h0000_0000, $urandom, FlashBaseReset};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Stray bytes before any record, a record cut short in its header by a colon,
    // then one data record with type high digit set, lowercase and extreme bytes
    // as data, and an odd trailing byte.
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    prelude = ":02FFFE0:03FFFE90a";
    foreach (prelude[i]) send_char(prelude[i], 1'b1);
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_char("F", 1'b1);
    send_char("7", 1'b1);

    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) write_base(bases[p]);
      send_gap_pct = (p == 1) ? 46 : (p == 3) ? 13 : 0;
      stall_pct    = (p == 2) ? 46 : (p == 3) ? 13 : 0;
      phase_start  = chars_sent;
      if (p == 2) begin
        // Longest data record, then filler to drive the position counter into saturation.
        send_record(8'hFF, KindData, -1);
        repeat (520) begin
          d = 8'($urandom);
          if (d == CharColon) d = CharZero;
          send_char(d, 1'b1);
        end
      end
      while (chars_sent < phase_start + CharsPerPhase) begin
        r   = $urandom_range(99);
        cnt = ($urandom_range(39) == 0) ? 8'($urandom_range(17, 255)) : 8'($urandom_range(0, 16));
        if (r < 78) begin
          send_record(cnt, KindData, -1);
        end else if (r < 86) begin
          send_record(cnt, 4'($urandom_range(1, 15)), -1);
        end else if (r < 93) begin
          send_record(cnt, KindData, $urandom_range(1, 10 + 2 * int'(cnt)));
        end else begin
          repeat ($urandom_range(1, 4)) send_char(8'($urandom), 1'b1);
        end
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d characters of hex records and noise over %0d phases", chars_sent,
             NumPhases);
    $display("of idle patterns and base addresses; %0d flash writes compared.", writes_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: hex_record_flash_writer_core.f
+incdir+hw/rtl
hw/rtl/hrfw_pkg.sv
hw/rtl/hrfw_parser.sv
hw/rtl/hex_record_flash_writer_core.sv
sim/hrfw_write_checker.sv
sim/hex_record_flash_writer_core_tb.sv
